// ----- design/dhf_pkg.sv -----
// Shared types, constants and tap tables of the depth hole-fill spatial filter.
package dhf_pkg;

    localparam int ALPHA_FRAC_BITS = 8;
    localparam int ALPHA_ONE       = 1 << ALPHA_FRAC_BITS;

    localparam int DEPTH_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GEOM_W     = 11;
    localparam int HOLE_W     = 3;
    localparam int ALPHA_W    = 9;
    localparam int SUM_W      = 20;
    localparam int CNT_W      = 4;
    localparam int P1_W       = ALPHA_W + DEPTH_W;
    localparam int P2_W       = ALPHA_W + SUM_W;
    localparam int NUM_W      = 30;
    localparam int X_W        = NUM_W + 1;
    localparam int DIV_W      = 22;
    localparam int DVS_W      = CNT_W + 1;
    localparam int TAP_W      = 4;

    localparam logic [TAP_W-1:0] TAP_N = 4'd9;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_HOLE_PASSES  = 3'd2;
    localparam t_cfg_idx CFG_SMOOTH_EN    = 3'd3;
    localparam t_cfg_idx CFG_BLEND_ALPHA  = 3'd4;
    localparam t_cfg_idx CFG_MAX_DELTA    = 3'd5;

    typedef struct packed {
        logic               action;
        logic [DEPTH_W-1:0] depth_in;
    } t_in_beat;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_out;
        logic               frame_last;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_CHECK, ST_WR, ST_RD, ST_MUL1, ST_MUL2,
        ST_DIVS, ST_DIVW, ST_RES, ST_NEXT, ST_FIN
    } t_state;

    typedef struct packed {
        logic             take;
        logic             prep;
        logic             init;
        logic             wr;
        logic             rd;
        logic [TAP_W-1:0] tap;
        logic             mul1;
        logic             mul2;
        logic             div_start;
        logic             res;
        logic             next;
        logic             fin;
    } t_cmd;

    typedef struct packed {
        logic ign_first;
        logic ign_flush;
        logic k_zero;
        logic fire;
        logic last_stage;
        logic div_busy;
        logic have;
        logic out_free;
    } t_sts;

    // Row offset code: 0 = row above, 1 = same row, 2 = row below. Centre comes first.
    function automatic logic [1:0] tap_dy(input logic [TAP_W-1:0] t);
        logic [1:0] d;
        case (t)
            4'd1, 4'd2, 4'd3: d = 2'd0;
            4'd6, 4'd7, 4'd8: d = 2'd2;
            default:          d = 2'd1;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] tap_dx(input logic [TAP_W-1:0] t);
        logic [1:0] d;
        case (t)
            4'd1, 4'd4, 4'd6: d = 2'd0;
            4'd3, 4'd5, 4'd8: d = 2'd2;
            default:          d = 2'd1;
        endcase
        return d;
    endfunction

endpackage

// ----- design/dhf_div.sv -----
// Restoring divider, one quotient bit per cycle.
module dhf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dhf_pkg::DIV_W-1:0]  i_dividend,
    input  logic [dhf_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [dhf_pkg::DIV_W-1:0]  o_quotient
);
    localparam int DW  = dhf_pkg::DIV_W;
    localparam int VW  = dhf_pkg::DVS_W;
    localparam int KW  = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic [VW:0]   trial;
    logic          ge;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        ge    = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= KW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? VW'(trial - {1'b0, r_dvs}) : VW'(trial);
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

// ----- design/dhf_ctrl.sv -----
// Sequencer: walks each beat through the active filter stages.
module dhf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dhf_pkg::t_sts   i_sts,
    output dhf_pkg::t_cmd   o_cmd
);
    dhf_pkg::t_state             r_state, n_state;
    logic [dhf_pkg::TAP_W-1:0]   r_tap, n_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhf_pkg::ST_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_tap      = r_tap;
        o_cmd      = '0;
        o_cmd.tap  = r_tap;
        o_in_ready = 1'b0;
        unique case (r_state)
            dhf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = dhf_pkg::ST_PREP;
                end
            end
            dhf_pkg::ST_PREP: begin
                if (i_sts.ign_first) begin
                    n_state = dhf_pkg::ST_IDLE;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = dhf_pkg::ST_CHECK;
                end
            end
            dhf_pkg::ST_CHECK: begin
                if (i_sts.ign_flush) begin
                    n_state = dhf_pkg::ST_IDLE;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = i_sts.k_zero ? dhf_pkg::ST_FIN : dhf_pkg::ST_WR;
                end
            end
            dhf_pkg::ST_WR: begin
                o_cmd.wr = 1'b1;
                n_tap    = '0;
                n_state  = i_sts.fire ? dhf_pkg::ST_RD : dhf_pkg::ST_NEXT;
            end
            dhf_pkg::ST_RD: begin
                o_cmd.rd = (r_tap != dhf_pkg::TAP_N);
                if (r_tap == dhf_pkg::TAP_N) begin
                    n_tap   = '0;
                    n_state = dhf_pkg::ST_MUL1;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            dhf_pkg::ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = dhf_pkg::ST_MUL2;
            end
            dhf_pkg::ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = dhf_pkg::ST_DIVS;
            end
            dhf_pkg::ST_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = dhf_pkg::ST_DIVW;
            end
            dhf_pkg::ST_DIVW: begin
                if (!i_sts.div_busy) begin
                    n_state = dhf_pkg::ST_RES;
                end
            end
            dhf_pkg::ST_RES: begin
                o_cmd.res = 1'b1;
                n_state   = dhf_pkg::ST_NEXT;
            end
            dhf_pkg::ST_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = i_sts.last_stage ? dhf_pkg::ST_FIN : dhf_pkg::ST_WR;
            end
            dhf_pkg::ST_FIN: begin
                if (!i_sts.have || i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = dhf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dhf_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ----- design/dhf_dp.sv -----
// Datapath: config registers, line store, window gather, arithmetic and output register.
module dhf_dp #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_HEIGHT      = 1024,
    parameter int MAX_HOLE_STAGES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [dhf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dhf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  dhf_pkg::t_in_beat               i_in_data,
    input  dhf_pkg::t_cmd                   i_cmd,
    output dhf_pkg::t_sts                   o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dhf_pkg::t_out_beat              o_out_data
);
    localparam int STAGE_COUNT = MAX_HOLE_STAGES + 1;
    localparam int HIST_LEN    = 2 * MAX_WIDTH + 3;
    localparam int MEM_DEPTH   = STAGE_COUNT * HIST_LEN;
    localparam int AW          = $clog2(MEM_DEPTH);
    localparam int PW          = $clog2(HIST_LEN);
    localparam int CW          = $clog2(MAX_WIDTH + 1);
    localparam int SPW         = $clog2(MAX_WIDTH + 2);
    localparam int RW          = $clog2(MAX_HEIGHT + 1);
    localparam int TOT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int NW          = $clog2(MAX_WIDTH * MAX_HEIGHT + STAGE_COUNT * (MAX_WIDTH + 1) + 1);
    localparam int SW          = $clog2(STAGE_COUNT + 1);
    localparam int SIW         = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int DEPTH_W     = dhf_pkg::DEPTH_W;
    localparam int NUM_W_L     = dhf_pkg::NUM_W;

    // configuration
    logic [dhf_pkg::GEOM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [dhf_pkg::HOLE_W-1:0]  r_cfg_hole;
    logic                        r_cfg_smooth;
    logic [dhf_pkg::ALPHA_W-1:0] r_cfg_alpha;
    logic [DEPTH_W-1:0]          r_cfg_delta;
    logic [CW-1:0]               cl_w;
    logic [RW-1:0]               cl_h;
    logic [SW-1:0]               cl_k;
    logic [dhf_pkg::ALPHA_W-1:0] cl_alpha;
    logic [TOT_W-1:0]            r_cfg_total;

    // frame latch
    logic [CW-1:0]               r_lat_w;
    logic [RW-1:0]               r_lat_h;
    logic [SW-1:0]               r_lat_k;
    logic [dhf_pkg::ALPHA_W-1:0] r_lat_alpha;
    logic [DEPTH_W-1:0]          r_lat_delta;
    logic [TOT_W-1:0]            r_lat_total;
    logic [SPW-1:0]              r_lat_span;
    logic [PW-1:0]               r_lat_w2;

    // item and stage walk
    logic                 r_act;
    logic [DEPTH_W-1:0]   r_din;
    logic [NW-1:0]        r_n;
    logic [PW-1:0]        r_p;
    logic [TOT_W-1:0]     r_ocnt;
    logic [SIW-1:0]       r_stage;
    logic [NW-1:0]        r_lag;
    logic [AW-1:0]        r_base;
    logic [PW-1:0]        r_wpos;
    logic [DEPTH_W-1:0]   r_val;
    logic                 r_have;
    logic                 r_fire;
    logic [RW-1:0]        r_srow [STAGE_COUNT];
    logic [CW-1:0]        r_scol [STAGE_COUNT];

    // line store and window
    logic [DEPTH_W-1:0]   r_mem [MEM_DEPTH];
    logic [DEPTH_W-1:0]   r_rd;
    logic                 r_acc_vld;
    logic                 r_acc_first;
    logic                 r_tap_ok;
    logic [DEPTH_W-1:0]   r_c;
    logic [dhf_pkg::SUM_W-1:0] r_sum;
    logic [dhf_pkg::CNT_W-1:0] r_cnt;
    logic [dhf_pkg::P1_W-1:0]  r_p1;
    logic [dhf_pkg::P2_W-1:0]  r_p2;
    logic [dhf_pkg::DIV_W-1:0] r_dvd;
    logic [dhf_pkg::DVS_W-1:0] r_dvs;
    logic                 r_byp;
    logic [DEPTH_W-1:0]   r_bypv;
    logic                 r_out_vld;
    dhf_pkg::t_out_beat   r_out;

    logic                 stg_smooth;
    logic                 fire;
    logic                 pixel_phase;
    logic [RW-1:0]        cr;
    logic [CW-1:0]        cc;
    logic [1:0]           dy, dx;
    logic [PW-1:0]        rowpart, back, rpos, npos;
    logic [AW-1:0]        raddr, waddr;
    logic                 tap_ok;
    logic [DEPTH_W-1:0]   v, diff;
    logic [NUM_W_L-1:0]   num;
    logic [dhf_pkg::X_W-1:0] xv;
    logic [dhf_pkg::DIV_W-1:0] quo;
    logic                 div_busy;
    logic                 last_px;
    logic [PW-1:0]        p_inc;

    always_comb begin
        if (r_cfg_w == '0)                 cl_w = CW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH)  cl_w = CW'(MAX_WIDTH);
        else                               cl_w = CW'(r_cfg_w);
        if (r_cfg_h == '0)                 cl_h = RW'(1);
        else if (32'(r_cfg_h) > MAX_HEIGHT) cl_h = RW'(MAX_HEIGHT);
        else                               cl_h = RW'(r_cfg_h);
        if (!r_cfg_smooth)                         cl_k = '0;
        else if (32'(r_cfg_hole) > MAX_HOLE_STAGES) cl_k = SW'(STAGE_COUNT);
        else                                       cl_k = SW'(r_cfg_hole) + 1'b1;
        if (32'(r_cfg_alpha) > dhf_pkg::ALPHA_ONE)
            cl_alpha = dhf_pkg::ALPHA_W'(dhf_pkg::ALPHA_ONE);
        else
            cl_alpha = r_cfg_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w      <= dhf_pkg::GEOM_W'(640);
            r_cfg_h      <= dhf_pkg::GEOM_W'(480);
            r_cfg_hole   <= dhf_pkg::HOLE_W'(2);
            r_cfg_smooth <= 1'b1;
            r_cfg_alpha  <= dhf_pkg::ALPHA_W'(115);
            r_cfg_delta  <= DEPTH_W'(20);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dhf_pkg::CFG_FRAME_WIDTH:  r_cfg_w      <= i_cfg_data[dhf_pkg::GEOM_W-1:0];
                dhf_pkg::CFG_FRAME_HEIGHT: r_cfg_h      <= i_cfg_data[dhf_pkg::GEOM_W-1:0];
                dhf_pkg::CFG_HOLE_PASSES:  r_cfg_hole   <= i_cfg_data[dhf_pkg::HOLE_W-1:0];
                dhf_pkg::CFG_SMOOTH_EN:    r_cfg_smooth <= i_cfg_data[0];
                dhf_pkg::CFG_BLEND_ALPHA:  r_cfg_alpha  <= i_cfg_data[dhf_pkg::ALPHA_W-1:0];
                dhf_pkg::CFG_MAX_DELTA:    r_cfg_delta  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cfg_total <= TOT_W'(cl_w * cl_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_w     <= CW'(1);
            r_lat_h     <= RW'(1);
            r_lat_k     <= '0;
            r_lat_alpha <= '0;
            r_lat_delta <= '0;
            r_lat_total <= TOT_W'(1);
            r_lat_span  <= SPW'(2);
            r_lat_w2    <= PW'(2);
        end else if (i_cmd.prep && r_n == '0) begin
            r_lat_w     <= cl_w;
            r_lat_h     <= cl_h;
            r_lat_k     <= cl_k;
            r_lat_alpha <= cl_alpha;
            r_lat_delta <= r_cfg_delta;
            r_lat_total <= r_cfg_total;
            r_lat_span  <= SPW'(cl_w) + 1'b1;
            r_lat_w2    <= PW'({cl_w, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_act <= i_in_data.action;
            r_din <= i_in_data.depth_in;
        end
    end

    // status
    always_comb begin
        pixel_phase = r_n < NW'(r_lat_total);
        stg_smooth  = (SW'(r_stage) + 1'b1) == r_lat_k;
        fire        = (r_n >= r_lag) && (r_srow[r_stage] < r_lat_h);
        o_sts.ign_first  = (r_n == '0) && r_act;
        o_sts.ign_flush  = pixel_phase && r_act;
        o_sts.k_zero     = r_lat_k == '0;
        o_sts.fire       = fire;
        o_sts.last_stage = stg_smooth;
        o_sts.div_busy   = div_busy;
        o_sts.have       = r_have;
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    // tap address and frame-edge mask
    always_comb begin
        cr = r_srow[r_stage];
        cc = r_scol[r_stage];
        dy = dhf_pkg::tap_dy(i_cmd.tap);
        dx = dhf_pkg::tap_dx(i_cmd.tap);
        case (dy)
            2'd0:    rowpart = r_lat_w2;
            2'd1:    rowpart = PW'(r_lat_w);
            default: rowpart = '0;
        endcase
        back = rowpart + PW'(2'd2 - dx);
        if (r_wpos >= back) rpos = r_wpos - back;
        else rpos = PW'((PW+1)'(r_wpos) + (PW+1)'(HIST_LEN) - (PW+1)'(back));
        if (r_wpos >= PW'(r_lat_span)) npos = r_wpos - PW'(r_lat_span);
        else npos = PW'((PW+1)'(r_wpos) + (PW+1)'(HIST_LEN) - (PW+1)'(r_lat_span));
        raddr = r_base + AW'(rpos);
        waddr = r_base + AW'(r_wpos);
        tap_ok = !(dy == 2'd0 && cr == '0)
              && !(dy == 2'd2 && ({1'b0, cr} + 1'b1) >= {1'b0, r_lat_h})
              && !(dx == 2'd0 && cc == '0)
              && !(dx == 2'd2 && ({1'b0, cc} + 1'b1) >= {1'b0, r_lat_w});
        p_inc = (r_p == PW'(HIST_LEN - 1)) ? '0 : r_p + 1'b1;
        last_px = ({1'b0, r_ocnt} + 1'b1) >= {1'b0, r_lat_total};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && r_have) begin
            r_mem[waddr] <= r_val;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= 1'b0;
        end else begin
            r_acc_vld <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_tap_ok    <= tap_ok;
            r_acc_first <= i_cmd.tap == '0;
        end
    end

    // window accumulate
    always_comb begin
        v    = r_tap_ok ? r_rd : '0;
        diff = (v > r_c) ? v - r_c : r_c - v;
    end

    always_ff @(posedge i_clk) begin
        if (r_acc_vld) begin
            if (r_acc_first) begin
                r_c <= v;
                if (stg_smooth && v != '0) begin
                    r_sum <= dhf_pkg::SUM_W'(v);
                    r_cnt <= dhf_pkg::CNT_W'(1);
                end else begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end
            end else if (v != '0 && (!stg_smooth || diff <= r_lat_delta)) begin
                r_sum <= r_sum + dhf_pkg::SUM_W'(v);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // blend arithmetic
    always_comb begin
        num = NUM_W_L'(r_p1 * r_cnt) + NUM_W_L'(r_p2);
        xv  = {num, 1'b0} + (dhf_pkg::X_W'(r_cnt) << dhf_pkg::ALPHA_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p1 <= dhf_pkg::P1_W'((dhf_pkg::ALPHA_W'(dhf_pkg::ALPHA_ONE) - r_lat_alpha) * r_c);
            r_p2 <= dhf_pkg::P2_W'(r_lat_alpha * r_sum);
        end
        if (i_cmd.mul2) begin
            if (stg_smooth) begin
                r_dvd  <= dhf_pkg::DIV_W'(xv >> (dhf_pkg::ALPHA_FRAC_BITS + 1));
                r_dvs  <= dhf_pkg::DVS_W'(r_cnt);
                r_byp  <= (r_c == '0) || (r_cnt <= dhf_pkg::CNT_W'(1));
                r_bypv <= r_c;
            end else begin
                r_dvd  <= dhf_pkg::DIV_W'({r_sum, 1'b0}) + dhf_pkg::DIV_W'(r_cnt);
                r_dvs  <= {r_cnt, 1'b0};
                r_byp  <= (r_c != '0) || (r_cnt == '0);
                r_bypv <= r_c;
            end
        end
    end

    dhf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // stage walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_val   <= r_din;
            r_have  <= pixel_phase;
            r_stage <= '0;
            r_lag   <= NW'(r_lat_span);
            r_base  <= '0;
            r_wpos  <= r_p;
        end
        if (i_cmd.wr) begin
            r_fire <= fire;
        end
        if (i_cmd.res) begin
            r_val <= r_byp ? r_bypv : quo[DEPTH_W-1:0];
        end
        if (i_cmd.next) begin
            r_have  <= r_fire;
            r_stage <= r_stage + 1'b1;
            r_lag   <= r_lag + NW'(r_lat_span);
            r_base  <= r_base + AW'(HIST_LEN);
            r_wpos  <= npos;
        end
    end

    // frame position and per-stage centre position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_p    <= '0;
            r_ocnt <= '0;
            for (int s = 0; s < STAGE_COUNT; s++) begin
                r_srow[s] <= '0;
                r_scol[s] <= '0;
            end
        end else begin
            if (i_cmd.next && r_fire) begin
                if (({1'b0, r_scol[r_stage]} + 1'b1) == {1'b0, r_lat_w}) begin
                    r_scol[r_stage] <= '0;
                    r_srow[r_stage] <= r_srow[r_stage] + 1'b1;
                end else begin
                    r_scol[r_stage] <= r_scol[r_stage] + 1'b1;
                end
            end
            if (i_cmd.fin) begin
                if (r_have && last_px) begin
                    r_n    <= '0;
                    r_p    <= '0;
                    r_ocnt <= '0;
                    for (int s = 0; s < STAGE_COUNT; s++) begin
                        r_srow[s] <= '0;
                        r_scol[s] <= '0;
                    end
                end else begin
                    r_n <= r_n + 1'b1;
                    r_p <= p_inc;
                    if (r_have) begin
                        r_ocnt <= r_ocnt + 1'b1;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.fin && r_have) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && r_have) begin
            r_out.depth_out  <= r_val;
            r_out.frame_last <= last_px;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
endmodule

// ----- design/depth_hole_fill_spatial_filter.sv -----
// Top level of the depth hole-fill and edge-preserving spatial filter.
//   channel | signals                                       | beat
//   in      | i_in_valid / o_in_ready / i_in_data           | action, depth_in
//   out     | o_out_valid / i_out_ready / o_out_data        | depth_out, frame_last
//   cfg     | i_cfg_valid / o_cfg_ready / i_cfg_index, data | register write
// One beat at a time: bookkeeping, then for each active stage a window write and,
// when its window is due, the tap read slots, two multiplies and the 22-bit divide.
// An ignored flush tick returns to idle without a result.
// Reset is synchronous; the line store needs no clearing pass.
// A pending result may sit in the output register while the next beat is worked on;
// the walk stalls at its end only if that register is still full.
module depth_hole_fill_spatial_filter #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_HEIGHT      = 1024,
    parameter int MAX_HOLE_STAGES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dhf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dhf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dhf_pkg::t_in_beat               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dhf_pkg::t_out_beat              o_out_data
);
    dhf_pkg::t_cmd cmd;
    dhf_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    dhf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dhf_dp #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .MAX_HOLE_STAGES (MAX_HOLE_STAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule
